// ----- sv/dsfm_pkg.sv -----
// Shared types, constants and codes for the direct-sound FIFO mixer.
package dsfm_pkg;

  // Default FIFO depth per channel
  localparam int FIFO_DEPTH_DEF = 32;

  // Input item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_TIMER = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Result kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Output sides
  localparam logic SIDE_RIGHT = 1'b0;
  localparam logic SIDE_LEFT  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_VOLUME_A = 3'd0;
  localparam logic [2:0] REG_VOLUME_B = 3'd1;
  localparam logic [2:0] REG_ENABLES  = 3'd2;
  localparam logic [2:0] REG_TIMER_A  = 3'd3;
  localparam logic [2:0] REG_TIMER_B  = 3'd4;
  localparam logic [2:0] REG_BIAS     = 3'd5;

  localparam int CFG_DATA_W = 9;
  localparam logic [8:0] BIAS_RESET = 9'd256;

  // Tick accumulator: 12 stored bits, 13 while a tick is worked off
  localparam int ACC_W      = 12;
  localparam int ACC_WORK_W = 13;
  localparam logic [ACC_WORK_W-1:0] ACC_STEP = 13'd512;
  localparam logic [2:0] MAX_PAIRS = 3'd4;

  // Mixer constants
  localparam int MIX_W = 15;
  localparam int SUM_W = 12;
  localparam logic signed [SUM_W-1:0] CLAMP_MAX = 12'sh3FF;
  localparam logic signed [10:0] MIX_CENTER = 11'sh200;

  // Control bundle from the sequencer to the mix unit
  typedef struct packed {
    logic       en_a;
    logic       en_b;
    logic       full_a;
    logic       full_b;
    logic [8:0] bias;
  } mix_ctrl_t;

endpackage

// ----- sv/dsfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dsfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dsfm_mix.sv -----
// Mix unit: scales enabled channels, adds bias, clamps, centers and scales by 20.
module dsfm_mix
  import dsfm_pkg::*;
(
  input  mix_ctrl_t               ctrl,
  input  logic signed [7:0]       sample_a,
  input  logic signed [7:0]       sample_b,
  output logic signed [MIX_W-1:0] mixed
);

  logic signed [SUM_W-1:0] term_a;
  logic signed [SUM_W-1:0] term_b;
  logic signed [SUM_W-1:0] sum;
  logic        [9:0]       clamped;
  logic signed [10:0]      centered;
  logic signed [MIX_W-1:0] wide;

  // Channel terms, x2 or x4
  always_comb begin
    term_a = '0;
    term_b = '0;
    if (ctrl.en_a) begin
      term_a = ctrl.full_a ? (SUM_W'(sample_a) <<< 2) : (SUM_W'(sample_a) <<< 1);
    end
    if (ctrl.en_b) begin
      term_b = ctrl.full_b ? (SUM_W'(sample_b) <<< 2) : (SUM_W'(sample_b) <<< 1);
    end
  end

  assign sum = term_a + term_b + $signed({3'b000, ctrl.bias});

  // Clamp to 0..1023
  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > CLAMP_MAX) begin
      clamped = CLAMP_MAX[9:0];
    end else begin
      clamped = sum[9:0];
    end
  end

  // Center and multiply by 20 as 16x + 4x
  assign centered = $signed({1'b0, clamped}) - MIX_CENTER;
  assign wide     = MIX_W'(centered);
  assign mixed    = (wide <<< 4) + (wide <<< 2);

endmodule

// ----- sv/direct_sound_fifo_mixer_unit.sv -----
// Top level: direct-sound FIFO mixer with sequencer, FIFO RAM and output register.
//
// Input channel (in_valid/in_ready): one item is a tick, a timer overflow or a
// FIFO byte write, chosen by func. in_ready is high only while the sequencer is
// idle; a write or an unused func finishes in the accept cycle.
// Output channel (out_valid/out_ready): one registered result slot. A tick gives
// up to four right/left pairs, one sample at a time, then a closing step that
// stores the accumulator. A timer overflow walks FIFO A then B; for each FIFO
// it matches the timer and issues the RAM read, loads the sample, then requests.
// The single shared mix unit and the one RAM read port make it work one step at a time.
// When the receiver stalls, the sequencer holds in place until the slot frees;
// no result is lost. 'last' marks the final result of an item.
// Configuration: cfg_we writes cfg_data into register cfg_index at once; it must
// be written only while the block is idle; the block itself does not enforce this.
// Reset (rst, synchronous): accumulator, FIFO pointers and counts, current
// samples cleared, registers to defaults (bias 256); FIFO RAM content is
// undefined and never read before it is written.
module direct_sound_fifo_mixer_unit
  import dsfm_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [10:0]             tick_count,
  input  logic [1:0]              timer_id,
  input  logic                    fifo_select,
  input  logic signed [7:0]       sample_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    kind,
  output logic                    side,
  output logic signed [MIX_W-1:0] mixed_value,
  output logic                    request_fifo,
  output logic                    last
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int AW    = $clog2(2 * FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(FIFO_DEPTH / 2);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [AW-1:0]    B_BASE   = AW'(FIFO_DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_TICK_L = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_REQ    = 3'd5;

  // Configuration registers
  logic       volume_a_full;
  logic       volume_b_full;
  logic [3:0] output_enables;
  logic       timer_for_a;
  logic       timer_for_b;
  logic [8:0] bias_level;

  // Block state
  logic [2:0]            state;
  logic [ACC_W-1:0]      acc;
  logic [ACC_WORK_W-1:0] acc_work;
  logic [2:0]            pairs;
  logic [1:0]            tid;
  logic                  pf;
  logic [PTR_W-1:0]      rp  [2];
  logic [CNT_W-1:0]      cnt [2];
  logic signed [7:0]     cur [2];

  // Datapath signals
  logic                    accept;
  logic                    slot_free;
  logic                    more_pairs;
  logic                    out_load;
  logic [CNT_W:0]          wsum;
  logic [PTR_W-1:0]        wp;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  logic [7:0]              rdata;
  logic                    sel_match;
  logic [CNT_W-1:0]        cnt_b_after;
  logic                    b_req;
  logic                    mix_side;
  mix_ctrl_t               mix_ctrl;
  logic signed [MIX_W-1:0] mix_out;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign more_pairs = (acc_work > ACC_STEP) && (pairs != MAX_PAIRS);

  // A result enters the output slot this cycle
  assign out_load = slot_free && (((state == S_TICK) && more_pairs) ||
                                  (state == S_TICK_L) ||
                                  ((state == S_REQ) && (cnt[pf] <= CNT_HALF)));

  // Push address: read pointer plus fill count, wrapped
  assign wsum  = (CNT_W + 1)'(rp[fifo_select]) + {1'b0, cnt[fifo_select]};
  assign wp    = (wsum >= (CNT_W + 1)'(FIFO_DEPTH)) ?
                 PTR_W'(wsum - (CNT_W + 1)'(FIFO_DEPTH)) : PTR_W'(wsum);
  assign waddr = fifo_select ? (B_BASE + AW'(wp)) : AW'(wp);
  assign we    = accept && (func == FUNC_WRITE) && (cnt[fifo_select] != CNT_FULL);

  // Pop address
  assign raddr = pf ? (B_BASE + AW'(rp[pf])) : AW'(rp[pf]);

  // Timer match and look-ahead on FIFO B's request for the last flag
  assign sel_match   = ({1'b0, (pf ? timer_for_b : timer_for_a)} == tid);
  assign cnt_b_after = (cnt[1] == '0) ? '0 : cnt[1] - 1'b1;
  assign b_req       = ({1'b0, timer_for_b} == tid) && (cnt_b_after <= CNT_HALF);

  // Mix unit control
  assign mix_side        = (state == S_TICK_L);
  assign mix_ctrl.en_a   = mix_side ? output_enables[1] : output_enables[0];
  assign mix_ctrl.en_b   = mix_side ? output_enables[3] : output_enables[2];
  assign mix_ctrl.full_a = volume_a_full;
  assign mix_ctrl.full_b = volume_b_full;
  assign mix_ctrl.bias   = bias_level;

  dsfm_ram #(
    .WIDTH (8),
    .DEPTH (2 * FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (sample_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  dsfm_mix u_mix (
    .ctrl     (mix_ctrl),
    .sample_a (cur[0]),
    .sample_b (cur[1]),
    .mixed    (mix_out)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_a_full  <= 1'b0;
      volume_b_full  <= 1'b0;
      output_enables <= '0;
      timer_for_a    <= 1'b0;
      timer_for_b    <= 1'b0;
      bias_level     <= BIAS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME_A: volume_a_full  <= cfg_data[0];
        REG_VOLUME_B: volume_b_full  <= cfg_data[0];
        REG_ENABLES:  output_enables <= cfg_data[3:0];
        REG_TIMER_A:  timer_for_a    <= cfg_data[0];
        REG_TIMER_B:  timer_for_b    <= cfg_data[0];
        REG_BIAS:     bias_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output slot valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, FIFO bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      acc_work  <= '0;
      pairs     <= '0;
      pf        <= 1'b0;
      rp[0]     <= '0;
      rp[1]     <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      cur[0]    <= '0;
      cur[1]    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            tid <= timer_id;
            case (func)
              FUNC_TICK: begin
                acc_work <= {1'b0, acc} + ACC_WORK_W'(tick_count);
                pairs    <= '0;
                state    <= S_TICK;
              end
              FUNC_TIMER: begin
                pf    <= 1'b0;
                state <= S_POP;
              end
              FUNC_WRITE: begin
                if (we) begin
                  cnt[fifo_select] <= cnt[fifo_select] + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (!more_pairs) begin
            acc   <= acc_work[ACC_W-1:0];
            state <= S_IDLE;
          end else if (slot_free) begin
            kind         <= KIND_SAMPLE;
            side         <= SIDE_RIGHT;
            mixed_value  <= mix_out;
            request_fifo <= 1'b0;
            last         <= 1'b0;
            acc_work     <= acc_work - ACC_STEP;
            pairs        <= pairs + 1'b1;
            state        <= S_TICK_L;
          end
        end
        S_TICK_L: begin
          if (slot_free) begin
            kind         <= KIND_SAMPLE;
            side         <= SIDE_LEFT;
            mixed_value  <= mix_out;
            request_fifo <= 1'b0;
            last         <= !more_pairs;
            state        <= S_TICK;
          end
        end
        S_POP: begin
          if (!sel_match) begin
            pf    <= 1'b1;
            state <= pf ? S_IDLE : S_POP;
          end else if (cnt[pf] != '0) begin
            // Read issued now; data lands in S_LOAD
            rp[pf]  <= (rp[pf] == PTR_LAST) ? '0 : rp[pf] + 1'b1;
            cnt[pf] <= cnt[pf] - 1'b1;
            state   <= S_LOAD;
          end else begin
            state <= S_REQ;
          end
        end
        S_LOAD: begin
          cur[pf] <= rdata;
          state   <= S_REQ;
        end
        S_REQ: begin
          if (cnt[pf] > CNT_HALF) begin
            pf    <= 1'b1;
            state <= pf ? S_IDLE : S_POP;
          end else if (slot_free) begin
            kind         <= KIND_REQUEST;
            side         <= SIDE_RIGHT;
            mixed_value  <= '0;
            request_fifo <= pf;
            last         <= pf || !b_req;
            pf           <= 1'b1;
            state        <= pf ? S_IDLE : S_POP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/direct_sound_fifo_mixer_unit_tb.sv -----
// Self-checking testbench for the direct-sound FIFO mixer unit.
module direct_sound_fifo_mixer_unit_tb
  import dsfm_pkg::*;
();

  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic FIFO_A = 1'b0;
  localparam logic FIFO_B = 1'b1;
  localparam int MIX_GAIN = 20;
  localparam int MAX_TICK_RESULTS = 8;
  localparam int MAX_WAIT = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    logic                    kind;
    logic                    side;
    logic signed [MIX_W-1:0] value;
    logic                    req;
    logic                    last;
  } audio_result_t;

  // DUT ports; the driven inputs are all known from time zero
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              func = FUNC_TICK;
  logic [10:0]             tick_count = '0;
  logic [1:0]              timer_id = '0;
  logic                    fifo_select = FIFO_A;
  logic signed [7:0]       sample_byte = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    kind;
  logic                    side;
  logic signed [MIX_W-1:0] mixed_value;
  logic                    request_fifo;
  logic                    last;

  // Mirror of the mixer state and registers
  int            tick_acc = 0;
  byte           fifo_mem [2][DEPTH];
  int            rd_ptr [2] = '{0, 0};
  int            fill_cnt [2] = '{0, 0};
  byte           cur_sample [2] = '{0, 0};
  bit            vol_full [2] = '{0, 0};
  bit [3:0]      out_en = '0;
  bit            tmr_sel [2] = '{0, 0};
  int            bias_lvl = int'(BIAS_RESET);

  audio_result_t expected_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  int            in_gap = 0;

  direct_sound_fifo_mixer_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One mixed output level for the given side
  function automatic int mix_level(bit sd);
    int sum;
    sum = 0;
    if (out_en[sd]) sum += int'(cur_sample[0]) * (vol_full[0] ? 4 : 2);
    if (out_en[int'(sd) + 2]) sum += int'(cur_sample[1]) * (vol_full[1] ? 4 : 2);
    sum += bias_lvl;
    if (sum < 0) sum = 0;
    if (sum > int'(CLAMP_MAX)) sum = int'(CLAMP_MAX);
    return (sum - int'(MIX_CENTER)) * MIX_GAIN;
  endfunction

  // Update the mirror for one accepted item and queue the results it causes
  task automatic predict_item(logic [1:0] f, logic [10:0] tc, logic [1:0] tid,
                              logic sel, logic signed [7:0] smp);
    int n;
    int wp;
    bit req [2];
    case (f)
      FUNC_TICK: begin
        tick_acc += int'(tc);
        n = 0;
        while (tick_acc > int'(ACC_STEP) && n < MAX_TICK_RESULTS) begin
          tick_acc -= int'(ACC_STEP);
          n += 2;
          expected_results.push_back(audio_result_t'{KIND_SAMPLE, SIDE_RIGHT,
                                     MIX_W'(mix_level(1'b0)), 1'b0, 1'b0});
          expected_results.push_back(audio_result_t'{KIND_SAMPLE, SIDE_LEFT,
                                     MIX_W'(mix_level(1'b1)), 1'b0,
                                     !(tick_acc > int'(ACC_STEP) &&
                                       n < MAX_TICK_RESULTS)});
        end
        tick_acc = tick_acc % (1 << ACC_W);
      end
      FUNC_TIMER: begin
        for (int k = 0; k < 2; k++) begin
          req[k] = 1'b0;
          if (int'(tmr_sel[k]) == int'(tid)) begin
            // empty FIFO: current sample stays, request still raised
            if (fill_cnt[k] != 0) begin
              cur_sample[k] = fifo_mem[k][rd_ptr[k]];
              rd_ptr[k] = (rd_ptr[k] + 1) % DEPTH;
              fill_cnt[k]--;
            end
            req[k] = (fill_cnt[k] <= DEPTH / 2);
          end
        end
        // side is zero in a refill request
        if (req[0])
          expected_results.push_back(audio_result_t'{KIND_REQUEST, SIDE_RIGHT, '0,
                                     FIFO_A, !req[1]});
        if (req[1])
          expected_results.push_back(audio_result_t'{KIND_REQUEST, SIDE_RIGHT, '0,
                                     FIFO_B, 1'b1});
      end
      FUNC_WRITE: begin
        // full FIFO drops the byte
        if (fill_cnt[sel] < DEPTH) begin
          wp = (rd_ptr[sel] + fill_cnt[sel]) % DEPTH;
          fifo_mem[sel][wp] = smp;
          fill_cnt[sel]++;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item and wait until it is taken; valid stays up for a zero gap
  task automatic send_item(logic [1:0] f, logic [10:0] tc, logic [1:0] tid,
                           logic sel, logic signed [7:0] smp);
    if (in_gap != 0) repeat (in_gap) @(posedge clk);
    in_valid    <= 1'b1;
    func        <= f;
    tick_count  <= tc;
    timer_id    <= tid;
    fifo_select <= sel;
    sample_byte <= smp;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_item(f, tc, tid, sel, smp);
    in_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (in_gap != 0) in_valid <= 1'b0;
  endtask

  // Drop valid, drain all results, then let any silent item finish
  task automatic finish_phase();
    if (in_gap == 0) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back; block must be idle
  task automatic apply_config(bit va, bit vb, logic [3:0] en, bit ta, bit tbs,
                              logic [8:0] bias);
    logic [CFG_DATA_W-1:0] vals [6];
    vals[REG_VOLUME_A] = CFG_DATA_W'(va);
    vals[REG_VOLUME_B] = CFG_DATA_W'(vb);
    vals[REG_ENABLES]  = CFG_DATA_W'(en);
    vals[REG_TIMER_A]  = CFG_DATA_W'(ta);
    vals[REG_TIMER_B]  = CFG_DATA_W'(tbs);
    vals[REG_BIAS]     = bias;
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    vol_full[0] = va;
    vol_full[1] = vb;
    out_en      = en;
    tmr_sel[0]  = ta;
    tmr_sel[1]  = tbs;
    bias_lvl    = int'(bias);
  endtask

  // Random items: mostly write bursts, matched timers and ticks, some noise
  task automatic run_traffic(int target);
    int counted;
    int r;
    int burst;
    logic sel;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        burst = ($urandom_range(0, 7) == 0) ? DEPTH + 8 : $urandom_range(1, 12);
        sel = 1'($urandom_range(0, 1));
        repeat (burst)
          send_item(FUNC_WRITE, 11'($urandom), 2'($urandom), sel, 8'($urandom));
        counted += burst;
      end else if (r < 60) begin
        send_item(FUNC_TIMER, 11'($urandom),
                  ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                             : 2'($urandom_range(2, 3)),
                  1'($urandom), 8'($urandom));
        counted++;
      end else if (r < 92) begin
        send_item(FUNC_TICK, 11'($urandom_range(0, 2047)), 2'($urandom),
                  1'($urandom), 8'($urandom));
        counted++;
      end else begin
        send_item(FUNC_UNUSED, 11'($urandom), 2'($urandom), 1'($urandom),
                  8'($urandom));
        counted++;
      end
    end
  endtask

  // Reset values: bias 256, outputs off, both FIFOs on timer 0 and empty
  task automatic test_reset_defaults();
    send_item(FUNC_TICK, 11'd513, 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd2, FIFO_B, 8'sd0);
    send_item(FUNC_UNUSED, 11'($urandom), 2'($urandom), 1'($urandom), 8'($urandom));
    finish_phase();
  endtask

  // Clamp at both ends, full tick of four pairs, unmatched timer, empty pop
  task automatic test_mix_extremes();
    apply_config(1'b1, 1'b1, 4'hF, 1'b0, 1'b1, 9'd511);
    send_item(FUNC_WRITE, 11'd0, 2'd0, FIFO_A, 8'sd127);
    send_item(FUNC_WRITE, 11'd0, 2'd0, FIFO_B, 8'sd127);
    send_item(FUNC_WRITE, 11'd0, 2'd0, FIFO_A, -8'sd128);
    send_item(FUNC_WRITE, 11'd0, 2'd0, FIFO_B, -8'sd128);
    send_item(FUNC_TIMER, 11'd0, 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd1, FIFO_A, 8'sd0);
    send_item(FUNC_TICK, 11'(int'(ACC_STEP) - tick_acc), 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TICK, 11'd2047, 2'd3, FIFO_B, -8'sd1);
    finish_phase();
    apply_config(1'b0, 1'b0, 4'hF, 1'b1, 1'b0, 9'd0);
    send_item(FUNC_TIMER, 11'd0, 2'd1, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd0, FIFO_A, 8'sd0);
    send_item(FUNC_TIMER, 11'd0, 2'd3, FIFO_A, 8'sd0);
    send_item(FUNC_TICK, 11'd2047, 2'd0, FIFO_A, 8'sd0);
    finish_phase();
  endtask

  // Random traffic under extreme and random settings
  task automatic test_fifo_traffic();
    apply_config(1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 9'd511);
    run_traffic(PHASE_ITEMS);
    finish_phase();
    apply_config(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0);
    run_traffic(PHASE_ITEMS);
    finish_phase();
    apply_config(1'($urandom), 1'($urandom), 4'($urandom), 1'($urandom),
                 1'($urandom), 9'($urandom));
    run_traffic(PHASE_ITEMS);
    finish_phase();
  endtask

  // Same traffic with both sides never idling
  task automatic test_back_to_back();
    apply_config(1'($urandom), 1'($urandom), 4'($urandom), 1'b0, 1'b1,
                 9'($urandom));
    no_idle = 1'b1;
    in_gap  = 0;
    run_traffic(PHASE_ITEMS);
    finish_phase();
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, every item compared with the oldest expectation
  initial begin
    audio_result_t want;
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d side %0d mixed_value %0d request_fifo %0d",
               kind, side, mixed_value, request_fifo);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          fail_count++;
        end
        if (side !== want.side) begin
          $error("side: expected %0d, actual %0d", want.side, side);
          fail_count++;
        end
        if (mixed_value !== want.value) begin
          $error("mixed_value: expected %0d, actual %0d", $signed(want.value),
                 mixed_value);
          fail_count++;
        end
        if (request_fifo !== want.req) begin
          $error("request_fifo: expected %0d, actual %0d", want.req, request_fifo);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("direct_sound_fifo_mixer_unit_tb NOT OK");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_mix_extremes();
    test_fifo_traffic();
    test_back_to_back();
    if (fail_count == 0)
      $display("direct_sound_fifo_mixer_unit_tb OK");
    else
      $display("direct_sound_fifo_mixer_unit_tb NOT OK");
    $finish;
  end

endmodule
